>>> design/uoc_pkg.sv
package uoc_pkg;

  localparam int unsigned EchoW   = 20;
  localparam int unsigned CmW     = 15;
  localparam int unsigned SumW    = 23;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ThrW    = 15;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned NumCh   = 3;
  localparam int unsigned ChW     = 2;

  localparam int unsigned UOC_MAX_ROUNDS = 255;

  // x / 58 == (x >> 1) / 29 == ((x >> 1) * 578525) >> 24 for x < 2^20
  localparam int unsigned CmHalfW  = EchoW - 1;
  localparam int unsigned RecipW   = 20;
  localparam int unsigned ProdW    = CmHalfW + RecipW;
  localparam int unsigned CmShift  = 24;
  localparam logic [RecipW-1:0] CmRecip = 20'd578525;

  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROUNDS    = 1'd1;

  localparam logic [ThrW-1:0]   ThrReset    = 15'd20;
  localparam logic [CountW-1:0] RoundsReset = 8'd5;

  localparam logic [CodeW-1:0] CODE_CLEAR = 2'd0;
  localparam logic [CodeW-1:0] CODE_LEFT  = 2'd1;
  localparam logic [CodeW-1:0] CODE_RIGHT = 2'd2;
  localparam logic [CodeW-1:0] CODE_AHEAD = 2'd3;

  localparam logic [ChW-1:0] CH_RIGHT  = 2'd0;
  localparam logic [ChW-1:0] CH_LEFT   = 2'd1;
  localparam logic [ChW-1:0] CH_CENTRE = 2'd2;

  typedef struct packed {
    logic           capture;
    logic           mul;
    logic           acc;
    logic [ChW-1:0] ch;
    logic           inc_count;
    logic           limit;
    logic           load_out;
  } uoc_cmd_t;

  typedef struct packed {
    logic decide;
  } uoc_status_t;

endpackage

>>> design/uoc_ctrl.sv
module uoc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  uoc_pkg::uoc_status_t status_i,
  output uoc_pkg::uoc_cmd_t    cmd_o
);
  import uoc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_LIMIT,
    ST_DECIDE
  } state_e;

  state_e         state_q, state_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic           out_valid_q, out_valid_d;
  logic           slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    cmd_o       = '0;
    cmd_o.ch    = ch_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          ch_d          = CH_RIGHT;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (ch_q == CH_CENTRE) begin
          cmd_o.inc_count = 1'b1;
          state_d         = ST_CHECK;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_CHECK: begin
        state_d = status_i.decide ? ST_LIMIT : ST_IDLE;
      end
      ST_LIMIT: begin
        cmd_o.limit = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= CH_RIGHT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/uoc_dp.sv
module uoc_dp #(
  parameter int unsigned MAX_ROUNDS = uoc_pkg::UOC_MAX_ROUNDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [uoc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [uoc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [uoc_pkg::EchoW-1:0]   echo_right_us_i,
  input  logic [uoc_pkg::EchoW-1:0]   echo_left_us_i,
  input  logic [uoc_pkg::EchoW-1:0]   echo_centre_us_i,
  input  uoc_pkg::uoc_cmd_t           cmd_i,
  output uoc_pkg::uoc_status_t        status_o,
  output logic [uoc_pkg::CodeW-1:0]   obstacle_code_o
);
  import uoc_pkg::*;

  localparam logic [15:0] MaxR = 16'(MAX_ROUNDS);

  logic [ThrW-1:0]    thr_q;
  logic [CountW-1:0]  rounds_q;
  logic [EchoW-1:0]   echo_q [NumCh];
  logic [SumW-1:0]    sum_q [NumCh];
  logic [CountW-1:0]  cnt_q;
  logic [ProdW-1:0]   prod_q;
  logic [SumW-1:0]    lim_lo_q;
  logic [SumW:0]      lim_hi_q;
  logic [CodeW-1:0]   code_q;

  logic [CmHalfW-1:0] half;
  logic [CmW-1:0]     cm;
  logic [SumW:0]      acc_sum;
  logic [SumW-1:0]    acc_sat;
  logic [15:0]        n_eff;
  logic [SumW-1:0]    thr_prod;
  logic [NumCh-1:0]   blocked, clear_s;
  logic [CodeW-1:0]   code_d;

  assign half    = echo_q[cmd_i.ch][EchoW-1:1];
  assign cm      = prod_q[CmShift +: CmW];
  assign acc_sum = {1'b0, sum_q[cmd_i.ch]} + (SumW+1)'(cm);
  assign acc_sat = acc_sum[SumW] ? '1 : acc_sum[SumW-1:0];

  always_comb begin
    n_eff = (rounds_q == '0) ? 16'd1 : {8'd0, rounds_q};
    if (n_eff > MaxR) begin
      n_eff = MaxR;
    end
  end

  assign status_o.decide = ({8'd0, cnt_q} >= n_eff);
  assign thr_prod        = SumW'(thr_q) * SumW'(cnt_q);

  // avg < thr  <=> sum < thr*n ; avg > thr <=> sum >= (thr+1)*n
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      blocked[i] = sum_q[i] < lim_lo_q;
      clear_s[i] = {1'b0, sum_q[i]} >= lim_hi_q;
    end
    if (!(blocked[CH_RIGHT] || clear_s[CH_RIGHT]) ||
        !(blocked[CH_LEFT] || clear_s[CH_LEFT]) ||
        !(blocked[CH_CENTRE] || clear_s[CH_CENTRE])) begin
      code_d = CODE_CLEAR;
    end else if (clear_s[CH_RIGHT] && blocked[CH_LEFT]) begin
      code_d = CODE_LEFT;
    end else if (blocked[CH_RIGHT] && clear_s[CH_LEFT]) begin
      code_d = CODE_RIGHT;
    end else begin
      code_d = blocked[CH_CENTRE] ? CODE_AHEAD : CODE_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrReset;
      rounds_q <= RoundsReset;
      cnt_q    <= '0;
      for (int i = 0; i < NumCh; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: thr_q    <= cfg_data_i[ThrW-1:0];
          CFG_ROUNDS:    rounds_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.acc) begin
        sum_q[cmd_i.ch] <= acc_sat;
      end
      if (cmd_i.inc_count) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        cnt_q <= '0;
        for (int i = 0; i < NumCh; i++) begin
          sum_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      echo_q[CH_RIGHT]  <= echo_right_us_i;
      echo_q[CH_LEFT]   <= echo_left_us_i;
      echo_q[CH_CENTRE] <= echo_centre_us_i;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(half) * ProdW'(CmRecip);
    end
    if (cmd_i.limit) begin
      lim_lo_q <= thr_prod;
      lim_hi_q <= {1'b0, thr_prod} + (SumW+1)'(cnt_q);
    end
    if (cmd_i.load_out) begin
      code_q <= code_d;
    end
  end

  assign obstacle_code_o = code_q;

endmodule

>>> design/ultrasonic_obstacle_classifier.sv
// Each word is captured, then each channel in turn is converted to cm and
// accumulated; a deciding word then sets its limits and loads its code once the
// output register is free. A word is taken only once the last is done, as the
// single shared cm-conversion multiplier steps through the three channels.
// Reset: async active low; sums and round count zero, threshold 20, rounds 5.
module ultrasonic_obstacle_classifier #(
  parameter int unsigned MAX_ROUNDS = uoc_pkg::UOC_MAX_ROUNDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [uoc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [uoc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [uoc_pkg::EchoW-1:0]   echo_right_us_i,
  input  logic [uoc_pkg::EchoW-1:0]   echo_left_us_i,
  input  logic [uoc_pkg::EchoW-1:0]   echo_centre_us_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [uoc_pkg::CodeW-1:0]   obstacle_code_o
);
  import uoc_pkg::*;

  uoc_cmd_t    cmd;
  uoc_status_t status;

  uoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  uoc_dp #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .echo_right_us_i  (echo_right_us_i),
    .echo_left_us_i   (echo_left_us_i),
    .echo_centre_us_i (echo_centre_us_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .obstacle_code_o  (obstacle_code_o)
  );

endmodule

>>> dv/ultrasonic_obstacle_classifier_tb.sv
module ultrasonic_obstacle_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uoc_pkg::*;

  localparam int unsigned UsPerCm    = 58;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DirRows    = 28;
  localparam logic [EchoW-1:0] EchoMax = '1;

  typedef enum logic [1:0] {SIDE_BLOCKED, SIDE_AT_THR, SIDE_CLEAR} side_e;
  typedef enum logic [1:0] {AIM_BELOW, AIM_AT, AIM_ABOVE, AIM_ANY} aim_e;

  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    data;
    logic [EchoW-1:0]   er;
    logic [EchoW-1:0]   el;
    logic [EchoW-1:0]   ec;
    logic               typed;
    logic [CodeW-1:0]   code;
  } step_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [EchoW-1:0]   echo_right_us_i = '0;
  logic [EchoW-1:0]   echo_left_us_i = '0;
  logic [EchoW-1:0]   echo_centre_us_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CodeW-1:0]   obstacle_code_o;

  ultrasonic_obstacle_classifier u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .echo_right_us_i  (echo_right_us_i),
    .echo_left_us_i   (echo_left_us_i),
    .echo_centre_us_i (echo_centre_us_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .obstacle_code_o  (obstacle_code_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // classifier state mirror
  logic [ThrW-1:0]   thr_q = ThrReset;
  logic [CountW-1:0] rounds_q = RoundsReset;
  logic [SumW-1:0]   sum_r = '0;
  logic [SumW-1:0]   sum_l = '0;
  logic [SumW-1:0]   sum_c = '0;
  logic [CountW-1:0] rounds_seen = '0;
  logic [CodeW-1:0]  codes_due[$];

  int     errors = 0;
  int     cycles = 0;
  int     snd_idle_pct = 0;
  int     rcv_stall_pct = 0;
  int     hold_len = 0;
  int     hold_reqs = 0;
  int     hold_acks = 0;
  int     hold_left = 0;
  step_t  script [DirRows];
  aim_e   aims [3];

  function automatic logic [SumW-1:0] add_cm(logic [SumW-1:0] sum, logic [EchoW-1:0] us);
    logic [SumW:0] t;
    t = (SumW+1)'(sum + us / UsPerCm);
    return t[SumW] ? '1 : t[SumW-1:0];
  endfunction

  function automatic side_e side_of(logic [SumW-1:0] avg);
    if (avg < thr_q) return SIDE_BLOCKED;
    if (avg > thr_q) return SIDE_CLEAR;
    return SIDE_AT_THR;
  endfunction

  function automatic logic [CodeW-1:0] obstacle_for(logic [SumW-1:0] ar, logic [SumW-1:0] al,
                                                    logic [SumW-1:0] ac);
    side_e sr;
    side_e sl;
    side_e sc;
    sr = side_of(ar);
    sl = side_of(al);
    sc = side_of(ac);
    if (sr == SIDE_AT_THR || sl == SIDE_AT_THR || sc == SIDE_AT_THR) return CODE_CLEAR;
    if (sr == SIDE_CLEAR && sl == SIDE_BLOCKED) return CODE_LEFT;
    if (sr == SIDE_BLOCKED && sl == SIDE_CLEAR) return CODE_RIGHT;
    return (sc == SIDE_BLOCKED) ? CODE_AHEAD : CODE_CLEAR;
  endfunction

  task automatic accumulate_round(input logic [EchoW-1:0] er, input logic [EchoW-1:0] el,
                                  input logic [EchoW-1:0] ec, output logic decided,
                                  output logic [CodeW-1:0] code);
    logic [CountW-1:0] need;
    sum_r = add_cm(sum_r, er);
    sum_l = add_cm(sum_l, el);
    sum_c = add_cm(sum_c, ec);
    rounds_seen = rounds_seen + 1'b1;
    need = (rounds_q == 0) ? CountW'(1) : rounds_q;
    if (need > UOC_MAX_ROUNDS) need = CountW'(UOC_MAX_ROUNDS);
    decided = (rounds_seen >= need);
    code = CODE_CLEAR;
    if (decided) begin
      code = obstacle_for(sum_r / rounds_seen, sum_l / rounds_seen, sum_c / rounds_seen);
      sum_r = '0;
      sum_l = '0;
      sum_c = '0;
      rounds_seen = '0;
    end
  endtask

  function automatic step_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t word_row(logic [EchoW-1:0] er, logic [EchoW-1:0] el,
                                     logic [EchoW-1:0] ec, logic typed, logic [CodeW-1:0] code);
    step_t s;
    s = '0;
    s.er = er;
    s.el = el;
    s.ec = ec;
    s.typed = typed;
    s.code = code;
    return s;
  endfunction

  function automatic logic [EchoW-1:0] echo_aimed(aim_e aim);
    int cm;
    int us;
    if (aim == AIM_ANY) return EchoW'($urandom);
    case (aim)
      AIM_BELOW: cm = (thr_q == 0) ? 0 : $urandom_range(0, int'(thr_q) - 1);
      AIM_AT:    cm = int'(thr_q);
      default:   cm = int'(thr_q) + 1 + $urandom_range(0, 200);
    endcase
    us = cm * UsPerCm + $urandom_range(0, UsPerCm - 1);
    if (us > int'(EchoMax)) us = int'(EchoMax);
    return us[EchoW-1:0];
  endfunction

  function automatic aim_e pick_aim();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return AIM_BELOW;
    if (r < 8) return AIM_ABOVE;
    if (r == 8) return AIM_AT;
    return AIM_ANY;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_THRESHOLD: thr_q = data[ThrW-1:0];
      CFG_ROUNDS:    rounds_q = data[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (codes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_word(input logic [EchoW-1:0] er, input logic [EchoW-1:0] el,
                           input logic [EchoW-1:0] ec, input logic typed,
                           input logic [CodeW-1:0] typed_code);
    logic             decided;
    logic [CodeW-1:0] code;
    cfg_we_i <= 1'b0;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_valid_i       <= 1'b1;
    echo_right_us_i  <= er;
    echo_left_us_i   <= el;
    echo_centre_us_i <= ec;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_round(er, el, ec, decided, code);
    if (typed) codes_due.push_back(typed_code);
    else if (decided) codes_due.push_back(code);
  endtask

  task automatic run_phase(input int thr, input int rounds, input int words, input int snd_pct,
                           input int rcv_pct, input int hold);
    logic [CfgW-1:0]  rdata;
    logic [EchoW-1:0] echo [3];
    settle();
    write_reg(CFG_THRESHOLD, CfgW'(thr));
    rdata = CfgW'($urandom);
    rdata[CountW-1:0] = CountW'(rounds);
    write_reg(CFG_ROUNDS, rdata);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    if (hold != 0) begin
      hold_len = hold;
      hold_reqs++;
    end
    repeat (words) begin
      if (rounds_seen == 0) foreach (aims[k]) aims[k] = pick_aim();
      foreach (echo[k]) echo[k] = echo_aimed(aims[k]);
      if ($urandom_range(0, 9) == 0) echo[$urandom_range(0, 2)] = EchoW'($urandom);
      send_word(echo[0], echo[1], echo[2], 1'b0, CODE_CLEAR);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_acks != hold_reqs) begin
      hold_acks   <= hold_reqs;
      hold_left   <= hold_len;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_codes
    logic [CodeW-1:0] due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (codes_due.size() == 0) begin
        $display("%0t: obstacle code %0d with none due", $time, obstacle_code_o);
        errors++;
      end else begin
        due = codes_due.pop_front();
        if (obstacle_code_o !== due) begin
          $display("%0t: obstacle code expected %0d got %0d", $time, due, obstacle_code_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d codes still due", $time, codes_due.size());
      $display("[ultrasonic_obstacle_classifier] ERROR");
      $finish;
    end
  end

  initial begin
    script = '{
      word_row('0, '0, '0, 1'b0, CODE_CLEAR),
      word_row('0, '0, '0, 1'b0, CODE_CLEAR),
      word_row('0, '0, '0, 1'b0, CODE_CLEAR),
      word_row('0, '0, '0, 1'b0, CODE_CLEAR),
      word_row('0, '0, '0, 1'b1, CODE_AHEAD),
      cfg_row(CFG_ROUNDS, CfgW'(1)),
      word_row(EchoMax, EchoMax, EchoMax, 1'b1, CODE_CLEAR),
      word_row(EchoMax, '0, '0, 1'b1, CODE_LEFT),
      word_row('0, EchoMax, EchoMax, 1'b1, CODE_RIGHT),
      word_row(EchoMax, EchoMax, '0, 1'b1, CODE_AHEAD),
      word_row('0, '0, EchoMax, 1'b1, CODE_CLEAR),
      // right average sits on the threshold
      word_row(EchoW'(1160), '0, '0, 1'b1, CODE_CLEAR),
      word_row(EchoW'(1217), EchoMax, '0, 1'b1, CODE_CLEAR),
      word_row(EchoW'(1159), EchoW'(1218), EchoMax, 1'b0, CODE_CLEAR),
      // zero rounds behaves as one
      cfg_row(CFG_ROUNDS, CfgW'(0)),
      word_row(EchoMax, '0, EchoW'(5), 1'b1, CODE_LEFT),
      cfg_row(CFG_THRESHOLD, CfgW'(0)),
      word_row('0, '0, '0, 1'b1, CODE_CLEAR),
      word_row(EchoW'(58), '0, EchoW'(57), 1'b1, CODE_CLEAR),
      word_row(EchoW'(58), EchoW'(58), EchoW'(58), 1'b1, CODE_CLEAR),
      cfg_row(CFG_THRESHOLD, '1),
      word_row(EchoMax, EchoMax, EchoMax, 1'b1, CODE_AHEAD),
      cfg_row(CFG_THRESHOLD, CfgW'(20)),
      cfg_row(CFG_ROUNDS, CfgW'(3)),
      word_row('0, EchoW'(2320), '0, 1'b0, CODE_CLEAR),
      word_row('0, EchoW'(2320), '0, 1'b0, CODE_CLEAR),
      // count lowered below rounds already collected
      cfg_row(CFG_ROUNDS, CfgW'(1)),
      word_row('0, '0, '0, 1'b0, CODE_CLEAR)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_word(script[i].er, script[i].el, script[i].ec, script[i].typed, script[i].code);
      end
    end

    run_phase(20, 1, 60, 0, 0, 0);
    run_phase($urandom_range(0, 400), $urandom_range(1, 4), 60, 84, 0, 0);
    run_phase($urandom_range(0, 400), 2, 60, 0, 84, 0);
    run_phase($urandom_range(0, 32767), 1, 60, 21, 21, 0);
    run_phase($urandom_range(0, 400), 1, 60, 0, 0, 300);
    run_phase(20000, 255, 285, 0, 0, 0);
    run_phase($urandom_range(0, 400), 0, 60, 21, 21, 0);
    run_phase(32767, 3, 60, 0, 0, 0);
    run_phase($urandom_range(0, 400), $urandom_range(5, 8), 60, 21, 21, 0);
    settle();

    if (errors == 0) begin
      $display("[ultrasonic_obstacle_classifier] OK");
    end else begin
      $display("[ultrasonic_obstacle_classifier] ERROR");
    end
    $finish;
  end

endmodule
